[rtl/ttc_pkg.sv]
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared widths and constants for the tap tempo clock generator.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int TIME_W       = 32;
    localparam int WINDOW_W     = 16;

    localparam int MAX_TAPS_DEF = 8;
    localparam int PPQ_DEF      = 24;

    localparam int unsigned MINUTE_US    = 60000000;
    localparam int unsigned START_BPM    = 120;
    localparam int unsigned MS_TO_US     = 1000;
    localparam int unsigned WINDOW_RESET = 2000;

endpackage

[rtl/ttc_if.sv]
// ----------------------------------------------------------------------------
// ttc_evt_if / ttc_res_if
// Valid/ready channels for events in and results out.
// ----------------------------------------------------------------------------
interface ttc_evt_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [ttc_pkg::TIME_W-1:0] time_ms;
    logic [ttc_pkg::TIME_W-1:0] time_us;

    modport source (output valid, output cmd, output time_ms, output time_us, input ready);
    modport sink   (input valid, input cmd, input time_ms, input time_us, output ready);
endinterface

interface ttc_res_if;
    logic                      valid;
    logic                      ready;
    logic                      clock_pulse;
    logic                      running;
    logic [ttc_pkg::TIME_W-1:0] period_us;

    modport source (output valid, output clock_pulse, output running, output period_us,
                    input ready);
    modport sink   (input valid, input clock_pulse, input running, input period_us,
                    output ready);
endinterface

[rtl/ttc_ring.sv]
// ----------------------------------------------------------------------------
// ttc_ring
// Tap time store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttc_ring #(
    parameter int DEPTH = ttc_pkg::MAX_TAPS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IDX_W-1:0]           waddr,
    input  logic [ttc_pkg::TIME_W-1:0] wdata,
    input  logic [IDX_W-1:0]           raddr,
    output logic [ttc_pkg::TIME_W-1:0] rdata
);

    logic [ttc_pkg::TIME_W-1:0] mem [DEPTH];
    logic [ttc_pkg::TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ttc_div.sv]
// ----------------------------------------------------------------------------
// ttc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttc_div #(
    parameter int W   = ttc_pkg::TIME_W,
    parameter int DVW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   dividend,
    input  logic [DVW-1:0] divisor,
    output logic [W-1:0]   quotient,
    output logic           busy,
    output logic           done
);

    localparam int CW = $clog2(W);

    logic [W-1:0]   quo_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

[rtl/tap_tempo_clock_generator.sv]
// ----------------------------------------------------------------------------
// Flow: a tick goes from idle straight to ST_DONE; a tap passes the check, write and
// read states, then, once two or more taps are held, two serial divides.
// Throughput: one event at a time; the next transfer is taken on return to idle.
// Reset clears control, counts, pulse time; sets period to 120 BPM, window to 2 s.
// The tap store is not cleared; only entries written since reset are read.
// ----------------------------------------------------------------------------
// tap_tempo_clock_generator
// Derives a pulse period from tap times and gates clock pulses on ticks.
// ----------------------------------------------------------------------------
module tap_tempo_clock_generator #(
    parameter int MAX_TAPS           = ttc_pkg::MAX_TAPS_DEF,
    parameter int PULSES_PER_QUARTER = ttc_pkg::PPQ_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         window_we,
    input  logic [ttc_pkg::WINDOW_W-1:0] window_wdata,
    ttc_evt_if.sink                      evt,
    ttc_res_if.source                    res
);

    localparam int TW     = ttc_pkg::TIME_W;
    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PPQ_W  = $clog2(PULSES_PER_QUARTER + 1);
    localparam int DVW    = (IDX_W > PPQ_W) ? IDX_W : PPQ_W;
    localparam logic [TW-1:0] PERIOD_RESET =
        TW'(ttc_pkg::MINUTE_US / (ttc_pkg::START_BPM * PULSES_PER_QUARTER));
    localparam logic [TW-1:0] MS_SCALE = TW'(ttc_pkg::MS_TO_US);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAP_CHK,
        ST_TAP_WR,
        ST_TAP_RD,
        ST_TAP_SPAN,
        ST_DIV1,
        ST_DIV2_GO,
        ST_DIV2,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [IDX_W-1:0]           head_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [TW-1:0]              period_reg;
    logic [TW-1:0]              last_pulse_reg;
    logic                       clock_on_reg;
    logic [ttc_pkg::WINDOW_W-1:0] window_reg;
    logic [TW-1:0]              now_reg;
    logic [TW-1:0]              prod_reg;
    logic                       pulse_reg;
    logic                       res_valid_reg;
    logic                       res_pulse_reg;
    logic                       res_running_reg;
    logic [TW-1:0]              res_period_reg;

    logic                       accept;
    logic [IDX_W-1:0]           head_prev;
    logic [IDX_W-1:0]           head_inc;
    logic [CNT_W:0]             old_sum;
    logic [IDX_W-1:0]           first_slot;
    logic [IDX_W-1:0]           raddr;
    logic [TW-1:0]              rdata;
    logic [TW-1:0]              gap;
    logic [TW-1:0]              tick_gap;
    logic                       ring_we;
    logic                       div_start;
    logic [TW-1:0]              div_dividend;
    logic [DVW-1:0]             div_divisor;
    logic [TW-1:0]              div_quotient;
    logic                       div_busy;
    logic                       div_done;
    logic [TW-1:0]              scaled;
    logic                       res_load;

    assign accept    = evt.valid && evt.ready;
    assign evt.ready = (state_reg == ST_IDLE);

    assign head_prev  = (head_reg == '0) ? IDX_W'(MAX_TAPS - 1) : head_reg - 1'b1;
    assign head_inc   = (head_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : head_reg + 1'b1;
    assign old_sum    = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(MAX_TAPS)
                        - (CNT_W + 1)'(count_reg);
    assign first_slot = (old_sum >= (CNT_W + 1)'(MAX_TAPS))
                        ? IDX_W'(old_sum - (CNT_W + 1)'(MAX_TAPS)) : IDX_W'(old_sum);
    assign raddr      = (state_reg == ST_TAP_RD) ? first_slot : head_prev;
    assign ring_we    = (state_reg == ST_TAP_WR);

    assign gap      = now_reg - rdata;
    assign tick_gap = evt.time_us - last_pulse_reg;

    assign div_start    = (state_reg == ST_TAP_SPAN) || (state_reg == ST_DIV2_GO);
    assign div_dividend = (state_reg == ST_DIV2_GO) ? prod_reg : gap;
    assign div_divisor  = (state_reg == ST_DIV2_GO) ? DVW'(PULSES_PER_QUARTER)
                                                    : DVW'(count_reg - 1'b1);
    assign scaled       = div_quotient * MS_SCALE;

    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    ttc_ring #(
        .DEPTH (MAX_TAPS),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (head_reg),
        .wdata (now_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    ttc_div #(
        .W   (TW),
        .DVW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            period_reg      <= PERIOD_RESET;
            last_pulse_reg  <= '0;
            clock_on_reg    <= 1'b0;
            window_reg      <= ttc_pkg::WINDOW_W'(ttc_pkg::WINDOW_RESET);
            prod_reg        <= '0;
            pulse_reg       <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (window_we)
            begin
                window_reg <= window_wdata;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (evt.cmd)
                        begin
                            pulse_reg <= 1'b0;
                            if (clock_on_reg && (tick_gap >= period_reg))
                            begin
                                pulse_reg      <= 1'b1;
                                last_pulse_reg <= evt.time_us;
                            end
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            pulse_reg <= 1'b0;
                            state_reg <= ST_TAP_CHK;
                        end
                    end
                end
                ST_TAP_CHK:
                begin
                    if ((count_reg != '0) && (gap > TW'(window_reg)))
                    begin
                        head_reg  <= '0;
                        count_reg <= '0;
                    end
                    state_reg <= ST_TAP_WR;
                end
                ST_TAP_WR:
                begin
                    head_reg <= head_inc;
                    if (count_reg != CNT_W'(MAX_TAPS))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= ST_TAP_RD;
                end
                ST_TAP_RD:
                begin
                    state_reg <= (count_reg >= CNT_W'(2)) ? ST_TAP_SPAN : ST_DONE;
                end
                ST_TAP_SPAN:
                begin
                    state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (div_done)
                    begin
                        prod_reg  <= scaled;
                        state_reg <= ST_DIV2_GO;
                    end
                end
                ST_DIV2_GO:
                begin
                    state_reg <= ST_DIV2;
                end
                ST_DIV2:
                begin
                    if (div_done)
                    begin
                        period_reg   <= div_quotient;
                        clock_on_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= evt.time_ms;
        end
        if (res_load)
        begin
            res_pulse_reg   <= pulse_reg;
            res_running_reg <= clock_on_reg;
            res_period_reg  <= period_reg;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.clock_pulse = res_pulse_reg;
    assign res.running     = res_running_reg;
    assign res.period_us   = res_period_reg;

    a_running_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(clock_on_reg))
        else $error("clock stopped after starting");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TAPS))
        else $error("tap count beyond store depth");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pulse_when_running: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && pulse_reg |-> clock_on_reg)
        else $error("pulse issued while stopped");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

endmodule
